@@ design/cpu8ie_pkg.sv @@
// Shared types and constants for the 8-bit CPU execute block.
// Holds the item, result, architectural state and packet structs plus the opcode codes.
// No dependencies.
`default_nettype none

package cpu8ie_pkg;

	localparam logic [5:0] OP_ORA = 6'd0;
	localparam logic [5:0] OP_AND = 6'd1;
	localparam logic [5:0] OP_EOR = 6'd2;
	localparam logic [5:0] OP_ADC = 6'd3;
	localparam logic [5:0] OP_SBC = 6'd4;
	localparam logic [5:0] OP_CMP = 6'd5;
	localparam logic [5:0] OP_CPX = 6'd6;
	localparam logic [5:0] OP_CPY = 6'd7;
	localparam logic [5:0] OP_DEC = 6'd8;
	localparam logic [5:0] OP_DEX = 6'd9;
	localparam logic [5:0] OP_DEY = 6'd10;
	localparam logic [5:0] OP_INC = 6'd11;
	localparam logic [5:0] OP_INX = 6'd12;
	localparam logic [5:0] OP_INY = 6'd13;
	localparam logic [5:0] OP_ASL = 6'd14;
	localparam logic [5:0] OP_ROL = 6'd15;
	localparam logic [5:0] OP_LSR = 6'd16;
	localparam logic [5:0] OP_ROR = 6'd17;
	localparam logic [5:0] OP_LDA = 6'd18;
	localparam logic [5:0] OP_STA = 6'd19;
	localparam logic [5:0] OP_LDX = 6'd20;
	localparam logic [5:0] OP_STX = 6'd21;
	localparam logic [5:0] OP_LDY = 6'd22;
	localparam logic [5:0] OP_STY = 6'd23;
	localparam logic [5:0] OP_TAX = 6'd24;
	localparam logic [5:0] OP_TXA = 6'd25;
	localparam logic [5:0] OP_TAY = 6'd26;
	localparam logic [5:0] OP_TYA = 6'd27;
	localparam logic [5:0] OP_TSX = 6'd28;
	localparam logic [5:0] OP_TXS = 6'd29;
	localparam logic [5:0] OP_PLA = 6'd30;
	localparam logic [5:0] OP_PHA = 6'd31;
	localparam logic [5:0] OP_PLP = 6'd32;
	localparam logic [5:0] OP_PHP = 6'd33;
	localparam logic [5:0] OP_BPL = 6'd34;
	localparam logic [5:0] OP_BMI = 6'd35;
	localparam logic [5:0] OP_BVC = 6'd36;
	localparam logic [5:0] OP_BVS = 6'd37;
	localparam logic [5:0] OP_BCC = 6'd38;
	localparam logic [5:0] OP_BCS = 6'd39;
	localparam logic [5:0] OP_BNE = 6'd40;
	localparam logic [5:0] OP_BEQ = 6'd41;
	localparam logic [5:0] OP_BRK = 6'd42;
	localparam logic [5:0] OP_RTI = 6'd43;
	localparam logic [5:0] OP_JSR = 6'd44;
	localparam logic [5:0] OP_RTS = 6'd45;
	localparam logic [5:0] OP_JMP = 6'd46;
	localparam logic [5:0] OP_BIT = 6'd47;
	localparam logic [5:0] OP_CLC = 6'd48;
	localparam logic [5:0] OP_SEC = 6'd49;
	localparam logic [5:0] OP_CLD = 6'd50;
	localparam logic [5:0] OP_SED = 6'd51;
	localparam logic [5:0] OP_CLI = 6'd52;
	localparam logic [5:0] OP_SEI = 6'd53;
	localparam logic [5:0] OP_CLV = 6'd54;
	localparam logic [5:0] OP_NOP = 6'd55;
	localparam logic [5:0] OP_KIL = 6'd56;

	localparam logic [7:0] FL_C = 8'h01;
	localparam logic [7:0] FL_I = 8'h04;
	localparam logic [7:0] FL_D = 8'h08;
	localparam logic [7:0] FL_B = 8'h10;
	localparam logic [7:0] FL_U = 8'h20;
	localparam logic [7:0] FL_V = 8'h40;

	localparam logic [7:0]  SP_RESET   = 8'hFF;
	localparam logic [15:0] BRK_VECTOR = 16'hFFFE;

	localparam logic KIND_STACK  = 1'b0;
	localparam logic KIND_RETIRE = 1'b1;

	typedef struct packed {
		logic [5:0]  opcode;
		logic [7:0]  operand;
		logic [15:0] jump_target;
		logic [1:0]  pc_advance;
		logic [7:0]  pulled_first;
		logic [7:0]  pulled_second;
		logic [7:0]  pulled_third;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [8:0]  stack_address;
		logic [7:0]  stack_data;
		logic [7:0]  modified_byte;
		logic        modified_valid;
		logic [15:0] next_pc;
		logic [7:0]  status_flags;
		logic        halted;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
		logic        stopped;
	} arch_t;

	// Everything one instruction reports: its pushes and its retire fields.
	typedef struct packed {
		logic [1:0]  n_push;
		logic [7:0]  sp_base;
		logic [7:0]  push0;
		logic [7:0]  push1;
		logic [7:0]  push2;
		logic [7:0]  mod_byte;
		logic        mod_valid;
		logic [15:0] next_pc;
		logic [7:0]  status;
		logic        halted;
	} pkt_t;

endpackage

`default_nettype wire

@@ design/cpu8_instruction_execute.sv @@
// Top level of the 8-bit CPU execute block: state registers, packet queue, result sequencer.
// Depends on cpu8ie_pkg and cpu8ie_exec.
//
// One decoded instruction is accepted per cycle and executed in the cycle of its transfer;
// A, X, Y, SP, P, PC and the halt flag update at that edge. Its results go into a two-entry
// packet queue and leave one per cycle while result_stall is low: first its stack writes in
// push order, then the retire result. An instruction without pushes therefore sustains one
// item per cycle while results are not stalled; PHA/PHP produce two results, JSR three and
// BRK four, and the item side stalls only while both queue entries are occupied.
`default_nettype none

module cpu8_instruction_execute (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  wire cpu8ie_pkg::item_t item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output cpu8ie_pkg::result_t    result
);
	import cpu8ie_pkg::*;

	arch_t       st_q;
	arch_t       st_nxt;
	pkt_t        pkt_nxt;
	pkt_t        pkt_q [2];
	pkt_t        head;
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic [1:0]  idx_q;
	logic        item_xfer;
	logic        result_xfer;
	logic        pop;

	cpu8ie_exec u_exec (
		.st   (st_q),
		.item (item),
		.nxt  (st_nxt),
		.pkt  (pkt_nxt)
	);

	assign item_stall   = count_q == 2'd2;
	assign item_xfer    = item_valid && !item_stall;
	assign result_valid = count_q != 2'd0;
	assign result_xfer  = result_valid && !result_stall;
	assign head         = pkt_q[rd_ptr_q];
	assign pop          = result_xfer && (idx_q == head.n_push);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.a       <= 8'd0;
			st_q.x       <= 8'd0;
			st_q.y       <= 8'd0;
			st_q.sp      <= SP_RESET;
			st_q.p       <= 8'd0;
			st_q.pc      <= 16'd0;
			st_q.stopped <= 1'b0;
			wr_ptr_q     <= 1'b0;
			rd_ptr_q     <= 1'b0;
			count_q      <= 2'd0;
			idx_q        <= 2'd0;
		end else begin
			if (item_xfer) begin
				st_q     <= st_nxt;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (result_xfer) begin
				idx_q <= pop ? 2'd0 : idx_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, item_xfer} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			pkt_q[wr_ptr_q] <= pkt_nxt;
		end
	end

	always_comb begin
		result = '0;
		if (idx_q == head.n_push) begin
			result.kind           = KIND_RETIRE;
			result.modified_byte  = head.mod_byte;
			result.modified_valid = head.mod_valid;
			result.next_pc        = head.next_pc;
			result.status_flags   = head.status;
			result.halted         = head.halted;
			result.last           = 1'b1;
		end else begin
			result.kind          = KIND_STACK;
			result.stack_address = {1'b1, head.sp_base - {6'd0, idx_q}};
			case (idx_q)
				2'd0:    result.stack_data = head.push0;
				2'd1:    result.stack_data = head.push1;
				default: result.stack_data = head.push2;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/cpu8ie_exec.sv @@
// Combinational execute logic: next architectural state and result packet of one item.
// Depends on cpu8ie_pkg.
`default_nettype none

module cpu8ie_exec (
	input  wire cpu8ie_pkg::arch_t st,
	input  wire cpu8ie_pkg::item_t item,
	output cpu8ie_pkg::arch_t      nxt,
	output cpu8ie_pkg::pkt_t       pkt
);
	import cpu8ie_pkg::*;

	logic [15:0] npc;
	logic [15:0] ret;
	logic [7:0]  m;
	logic [7:0]  addend;
	logic [8:0]  sum;
	logic [7:0]  sum_r;
	logic [7:0]  cmp_reg;
	logic [8:0]  diff;
	logic [7:0]  mod;
	logic        modv;
	logic        branch;
	logic        take;
	logic        c;

	always_comb begin
		m      = item.operand;
		c      = st.p[0];
		ret    = st.pc + 16'd2;
		addend = (item.opcode == OP_SBC) ? ~m : m;
		sum    = {1'b0, st.a} + {1'b0, addend} + {8'd0, c};
		sum_r  = sum[7:0];
		case (item.opcode)
			OP_CPX:  cmp_reg = st.x;
			OP_CPY:  cmp_reg = st.y;
			default: cmp_reg = st.a;
		endcase
		diff = {1'b0, cmp_reg} - {1'b0, m};
	end

	always_comb begin
		nxt    = st;
		npc    = st.pc + {14'd0, item.pc_advance};
		mod    = 8'd0;
		modv   = 1'b0;
		branch = 1'b0;
		take   = 1'b0;
		pkt    = '0;
		pkt.sp_base = st.sp;

		if (!st.stopped) begin
			unique case (item.opcode)
				OP_ORA: nxt.a = st.a | m;
				OP_AND: nxt.a = st.a & m;
				OP_EOR: nxt.a = st.a ^ m;
				OP_ADC, OP_SBC: begin
					nxt.a    = sum_r;
					nxt.p[6] = ((st.a ^ sum_r) & (addend ^ sum_r)) >> 7 != 8'd0;
					nxt.p[0] = sum[8];
				end
				OP_CMP, OP_CPX, OP_CPY: nxt.p[0] = !diff[8];
				OP_DEC: begin mod = m - 8'd1; modv = 1'b1; end
				OP_INC: begin mod = m + 8'd1; modv = 1'b1; end
				OP_DEX: nxt.x = st.x - 8'd1;
				OP_DEY: nxt.y = st.y - 8'd1;
				OP_INX: nxt.x = st.x + 8'd1;
				OP_INY: nxt.y = st.y + 8'd1;
				OP_ASL: begin mod = {m[6:0], 1'b0}; modv = 1'b1; nxt.p[0] = m[7]; end
				OP_ROL: begin mod = {m[6:0], c}; modv = 1'b1; nxt.p[0] = m[7]; end
				OP_LSR: begin mod = {1'b0, m[7:1]}; modv = 1'b1; nxt.p[0] = m[0]; end
				OP_ROR: begin mod = {c, m[7:1]}; modv = 1'b1; nxt.p[0] = m[0]; end
				OP_LDA: nxt.a = m;
				OP_STA: begin mod = st.a; modv = 1'b1; end
				OP_LDX: nxt.x = m;
				OP_STX: begin mod = st.x; modv = 1'b1; end
				OP_LDY: nxt.y = m;
				OP_STY: begin mod = st.y; modv = 1'b1; end
				OP_TAX: nxt.x = st.a;
				OP_TXA: nxt.a = st.x;
				OP_TAY: nxt.y = st.a;
				OP_TYA: nxt.a = st.y;
				OP_TSX: nxt.x = st.sp;
				OP_TXS: nxt.sp = st.x;
				OP_PLA: begin nxt.sp = st.sp + 8'd1; nxt.a = item.pulled_first; end
				OP_PHA: begin
					pkt.n_push = 2'd1; pkt.push0 = st.a; nxt.sp = st.sp - 8'd1;
				end
				OP_PLP: begin nxt.sp = st.sp + 8'd1; nxt.p = item.pulled_first; end
				OP_PHP: begin
					pkt.n_push = 2'd1; pkt.push0 = st.p | FL_B | FL_U;
					nxt.sp = st.sp - 8'd1;
				end
				OP_BPL: begin branch = 1'b1; take = !st.p[7]; end
				OP_BMI: begin branch = 1'b1; take = st.p[7]; end
				OP_BVC: begin branch = 1'b1; take = !st.p[6]; end
				OP_BVS: begin branch = 1'b1; take = st.p[6]; end
				OP_BCC: begin branch = 1'b1; take = !c; end
				OP_BCS: begin branch = 1'b1; take = c; end
				OP_BNE: begin branch = 1'b1; take = !st.p[1]; end
				OP_BEQ: begin branch = 1'b1; take = st.p[1]; end
				OP_BRK: begin
					pkt.n_push = 2'd3;
					pkt.push0  = ret[15:8];
					pkt.push1  = ret[7:0];
					pkt.push2  = st.p | FL_B | FL_U;
					nxt.sp     = st.sp - 8'd3;
					nxt.p      = st.p | FL_I | FL_B;
					npc        = BRK_VECTOR;
				end
				OP_RTI: begin
					nxt.sp = st.sp + 8'd3;
					nxt.p  = item.pulled_first & ~FL_B;
					npc    = {item.pulled_third, item.pulled_second};
				end
				OP_JSR: begin
					pkt.n_push = 2'd2;
					pkt.push0  = ret[15:8];
					pkt.push1  = ret[7:0];
					nxt.sp     = st.sp - 8'd2;
					npc        = item.jump_target;
				end
				OP_RTS: begin
					nxt.sp = st.sp + 8'd2;
					npc    = {item.pulled_second, item.pulled_first} + 16'd1;
				end
				OP_JMP: npc = item.jump_target;
				OP_BIT: begin
					nxt.p[1] = (st.a & m) == 8'd0;
					nxt.p[7] = m[7];
					nxt.p[6] = m[6];
				end
				OP_CLC: nxt.p = st.p & ~FL_C;
				OP_SEC: nxt.p = st.p | FL_C;
				OP_CLD: nxt.p = st.p & ~FL_D;
				OP_SED: nxt.p = st.p | FL_D;
				OP_CLI: nxt.p = st.p & ~FL_I;
				OP_SEI: nxt.p = st.p | FL_I;
				OP_CLV: nxt.p = st.p & ~FL_V;
				OP_KIL: begin nxt.stopped = 1'b1; npc = st.pc; end
				default: ;
			endcase

			// N and Z follow the byte that the operation produced.
			case (item.opcode)
				OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_TXA, OP_TYA, OP_PLA: begin
					nxt.p[7] = nxt.a[7]; nxt.p[1] = nxt.a == 8'd0;
				end
				OP_LDA: begin nxt.p[7] = m[7]; nxt.p[1] = m == 8'd0; end
				OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
					nxt.p[7] = nxt.x[7]; nxt.p[1] = nxt.x == 8'd0;
				end
				OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
					nxt.p[7] = nxt.y[7]; nxt.p[1] = nxt.y == 8'd0;
				end
				OP_CMP, OP_CPX, OP_CPY: begin
					nxt.p[7] = diff[7]; nxt.p[1] = diff[7:0] == 8'd0;
				end
				OP_DEC, OP_INC, OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
					nxt.p[7] = mod[7]; nxt.p[1] = mod == 8'd0;
				end
				default: ;
			endcase

			if (branch && take) begin
				npc = npc + {{8{m[7]}}, m};
			end
			nxt.pc = npc;
		end

		pkt.mod_byte  = modv ? mod : 8'd0;
		pkt.mod_valid = modv;
		pkt.next_pc   = nxt.pc;
		pkt.status    = nxt.p;
		pkt.halted    = nxt.stopped;
	end

endmodule

`default_nettype wire

@@ design/cpu8ie_checker.sv @@
// Port-level checks for the 8-bit CPU execute block, bound to its top level.
// Depends on cpu8ie_pkg and cpu8_instruction_execute.
`default_nettype none

module cpu8ie_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      item_valid,
	input wire                      item_stall,
	input wire cpu8ie_pkg::item_t   item,
	input wire                      result_valid,
	input wire                      result_stall,
	input wire cpu8ie_pkg::result_t result
);
	import cpu8ie_pkg::*;

	// A stalled result transfer keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_last_is_retire: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.last == result.kind)
		else $error("last flag disagrees with result kind");

	a_stack_page: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_STACK |-> result.stack_address[8])
		else $error("stack write outside page one");

	a_stack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_STACK |->
		result.next_pc == 16'd0 && result.status_flags == 8'd0 && !result.halted
		&& !result.modified_valid)
		else $error("retire fields set on a stack write");

	// Every item transfer leaves a result visible next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> result_valid)
		else $error("accepted item produced no result");

endmodule

bind cpu8_instruction_execute cpu8ie_checker u_cpu8ie_checker (.*);

`default_nettype wire
